// File: rtl/core/socs_pkg.sv
package socs_pkg;

	// Sizes of the mask space and of the OR list.
	localparam int MAX_BITS    = 12;
	localparam int LIST_DEPTH  = MAX_BITS + 1;
	localparam int STORE_DEPTH = 1 << MAX_BITS;

	localparam logic [MAX_BITS-1:0] STORE_LAST  = MAX_BITS'(STORE_DEPTH - 1);
	localparam logic [3:0]          LIST_FULL   = 4'(LIST_DEPTH);
	localparam logic [15:0]         HIST_MAX    = 16'hFFFF;
	localparam logic [15:0]         WEIGHT_INIT = 16'd1;

	// Occurrence reward: a base, then halving bonuses starting at REWARD_BONUS.
	localparam logic [10:0] REWARD_BASE  = 11'd1024;
	localparam logic [10:0] REWARD_BONUS = 11'd256;
	localparam logic [3:0]  BONUS_STEPS  = 4'd9;

	// Configuration register indexes.
	localparam logic CFG_WORD_BITS   = 1'b0;
	localparam logic CFG_USE_WEIGHTS = 1'b1;

	localparam logic [3:0] WORD_BITS_INIT = 4'd12;

	typedef enum logic [1:0] {
		ACT_PUSH   = 2'd0,
		ACT_LOAD   = 2'd1,
		ACT_FINISH = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		action_t              op;
		logic [MAX_BITS-1:0]  value;
		logic [15:0]          weight;
	} cmd_t;

	typedef struct packed {
		logic                 all_covered;
		logic [27:0]          weighted_cover;
		logic [25:0]          potential_score;
		logic [MAX_BITS-1:0]  covered_masks;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUSH,
		ST_PUSH_END,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} back_state_t;

	// Word bits as used: zero acts as one, large values clamp to MAX_BITS.
	function automatic logic [3:0] eff_bits(input logic [3:0] word_bits);
		logic [3:0] k;
		k = word_bits;
		if (k == 4'd0) begin
			k = 4'd1;
		end else if (k > 4'(MAX_BITS)) begin
			k = 4'(MAX_BITS);
		end
		return k;
	endfunction

	// Low k bits set.
	function automatic logic [MAX_BITS-1:0] bits_mask(input logic [3:0] k);
		return ~({MAX_BITS{1'b1}} << k);
	endfunction

endpackage

// File: rtl/core/socs_front.sv
module socs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [31:0]         s_axis_tdata,
	input  logic [1:0]          s_axis_tuser,
	input  logic [3:0]          word_bits,
	input  logic                clearing,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output socs_pkg::cmd_t      cmd
);

	socs_pkg::action_t                   act;
	socs_pkg::cmd_t                      cmd_s1;
	logic                                cmd_valid_s1;
	logic [socs_pkg::MAX_BITS-1:0]       kmask;
	logic                                take;

	assign act   = socs_pkg::action_t'(s_axis_tuser);
	assign kmask = socs_pkg::bits_mask(socs_pkg::eff_bits(word_bits));

	// Outside the clearing pass, the stage takes an item while it is empty or draining into the queue.
	assign s_axis_tready = !clearing && (!cmd_valid_s1 || cmd_ready);
	assign take          = s_axis_tvalid && s_axis_tready;

	// Unused action codes are accepted and dropped here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_s1 <= 1'b0;
		end else if (take) begin
			cmd_valid_s1 <= (act != socs_pkg::ACT_NONE);
		end else if (cmd_ready) begin
			cmd_valid_s1 <= 1'b0;
		end
	end

	// Elements are cut to k bits now; weight indexes keep all their bits.
	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.op     <= act;
			cmd_s1.weight <= s_axis_tdata[27:12];
			if (act == socs_pkg::ACT_PUSH) begin
				cmd_s1.value <= s_axis_tdata[11:0] & kmask;
			end else begin
				cmd_s1.value <= s_axis_tdata[11:0];
			end
		end
	end

	assign cmd_valid = cmd_valid_s1;
	assign cmd       = cmd_s1;

endmodule

// File: rtl/core/socs_queue.sv
module socs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  socs_pkg::cmd_t  in_cmd,
	output logic            out_valid,
	input  logic            out_ready,
	output socs_pkg::cmd_t  out_cmd
);

	socs_pkg::cmd_t  slot_q [4];
	logic [1:0]      wr_ptr_q;
	logic [1:0]      rd_ptr_q;
	logic [2:0]      count_q;
	logic            push;
	logic            pop;

	assign in_ready  = (count_q != 3'd4);
	assign out_valid = (count_q != 3'd0);
	assign out_cmd   = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (push && !pop) begin
				count_q <= count_q + 3'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 3'd1;
			end
		end
	end

	// Item slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

// File: rtl/core/socs_back.sv
module socs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3:0]          word_bits,
	input  logic                use_weights,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  socs_pkg::cmd_t      cmd,
	output logic                clearing,
	output logic                res_valid,
	input  logic                res_ready,
	output socs_pkg::result_t   res
);

	localparam int AW = socs_pkg::MAX_BITS;

	socs_pkg::back_state_t  state_q, state_d;

	// Sequencer registers.
	logic [AW-1:0]  ctr_q;
	logic [3:0]     j_q;
	logic [3:0]     n_q;
	logic [AW-1:0]  last_q;
	logic [AW-1:0]  elem_q;
	logic [AW-1:0]  list_q [socs_pkg::LIST_DEPTH];
	logic [AW-1:0]  next_q [socs_pkg::LIST_DEPTH];
	logic [3:0]     len_q;

	// Memories.
	logic [15:0]    hist_mem [socs_pkg::STORE_DEPTH];
	logic [15:0]    weight_mem [socs_pkg::STORE_DEPTH];

	// Histogram read pipeline and write forwarding.
	logic           hs_valid_s1;
	logic           hs_score_s1;
	logic [AW-1:0]  hs_addr_s1;
	logic [15:0]    hist_rdata_s1;
	logic [15:0]    weight_rdata_s1;
	logic           fwd_valid_q;
	logic [AW-1:0]  fwd_addr_q;
	logic [15:0]    fwd_data_q;

	// Score accumulators and output register.
	logic [AW-1:0]  cov_q;
	logic [25:0]    pot_q;
	logic [27:0]    wsum_q;
	logic           res_valid_q;
	socs_pkg::result_t res_q;

	// Combinational strobes.
	logic           rd_en;
	logic           rd_score;
	logic [AW-1:0]  rd_addr;
	logic           list_append;
	logic [AW-1:0]  list_val;
	logic [3:0]     list_idx;
	logic           res_load;
	logic           hist_we;
	logic [AW-1:0]  hist_waddr;
	logic [15:0]    hist_wdata;
	logic           weight_we;
	logic [AW-1:0]  weight_waddr;
	logic [15:0]    weight_wdata;

	logic [3:0]     k;
	logic [AW-1:0]  kmask;
	logic [15:0]    count;
	logic [3:0]     steps;
	logic [10:0]    reward;
	logic [3:0]     rank;
	logic [3:0]     half;
	logic [13:0]    term;
	logic           in_range;

	assign k     = socs_pkg::eff_bits(word_bits);
	assign kmask = socs_pkg::bits_mask(k);
	assign half  = k >> 1;

	// Next OR value of the push walk: the element first, then each stored value ORed.
	assign list_idx = j_q - 4'd1;
	always_comb begin
		if (j_q == 4'd0) begin
			list_val = elem_q;
		end else begin
			list_val = list_q[list_idx] | elem_q;
		end
	end

	// Next state and strobes.
	always_comb begin
		state_d     = state_q;
		cmd_ready   = 1'b0;
		rd_en       = 1'b0;
		rd_score    = 1'b0;
		rd_addr     = ctr_q;
		list_append = 1'b0;
		res_load    = 1'b0;
		unique case (state_q)
			socs_pkg::ST_CLEAR: begin
				if (ctr_q == socs_pkg::STORE_LAST) begin
					state_d = socs_pkg::ST_IDLE;
				end
			end
			socs_pkg::ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					unique case (cmd.op)
						socs_pkg::ACT_PUSH:   state_d = socs_pkg::ST_PUSH;
						socs_pkg::ACT_FINISH: state_d = socs_pkg::ST_SCAN;
						default:              state_d = socs_pkg::ST_IDLE;
					endcase
				end
			end
			socs_pkg::ST_PUSH: begin
				list_append = (j_q == 4'd0) ||
					(list_val != last_q && n_q < socs_pkg::LIST_FULL);
				rd_en   = list_append;
				rd_addr = list_val;
				if (j_q == len_q) begin
					state_d = socs_pkg::ST_PUSH_END;
				end
			end
			socs_pkg::ST_PUSH_END: begin
				state_d = socs_pkg::ST_IDLE;
			end
			socs_pkg::ST_SCAN: begin
				rd_en    = 1'b1;
				rd_score = 1'b1;
				if (ctr_q == socs_pkg::STORE_LAST) begin
					state_d = socs_pkg::ST_DRAIN;
				end
			end
			socs_pkg::ST_DRAIN: begin
				state_d = socs_pkg::ST_RESULT;
			end
			socs_pkg::ST_RESULT: begin
				if (!res_valid_q || res_ready) begin
					res_load = 1'b1;
					state_d  = socs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = socs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= socs_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sweep counter, push walk control and list length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q  <= '0;
			j_q    <= 4'd0;
			n_q    <= 4'd0;
			len_q  <= 4'd0;
		end else begin
			if (state_q == socs_pkg::ST_CLEAR || state_q == socs_pkg::ST_SCAN) begin
				ctr_q <= ctr_q + AW'(1);
			end
			if (state_q == socs_pkg::ST_IDLE) begin
				j_q <= 4'd0;
				n_q <= 4'd0;
			end
			if (state_q == socs_pkg::ST_PUSH) begin
				j_q <= j_q + 4'd1;
				if (list_append) begin
					n_q <= n_q + 4'd1;
				end
			end
			if (state_q == socs_pkg::ST_PUSH_END) begin
				len_q <= n_q;
			end
			if (res_load) begin
				len_q <= 4'd0;
			end
		end
	end

	// List payload: new list is built aside, then copied over at the end.
	always_ff @(posedge clk) begin
		if (state_q == socs_pkg::ST_IDLE && cmd_valid) begin
			elem_q <= cmd.value;
		end
		if (list_append) begin
			next_q[n_q] <= list_val;
			last_q      <= list_val;
		end
		if (state_q == socs_pkg::ST_PUSH_END) begin
			list_q <= next_q;
		end
	end

	// Histogram read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_valid_s1 <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			hs_valid_s1 <= rd_en;
			fwd_valid_q <= hist_we;
		end
	end

	always_ff @(posedge clk) begin
		hs_score_s1 <= rd_score;
		hs_addr_s1  <= rd_addr;
		fwd_addr_q  <= hist_waddr;
		fwd_data_q  <= hist_wdata;
	end

	// Count as seen after the write of the previous cycle.
	assign count = (fwd_valid_q && fwd_addr_q == hs_addr_s1) ? fwd_data_q : hist_rdata_s1;

	// Histogram write: clearing sweep, saturating increment, or zero after scoring.
	always_comb begin
		hist_we    = 1'b0;
		hist_waddr = hs_addr_s1;
		hist_wdata = '0;
		if (state_q == socs_pkg::ST_CLEAR) begin
			hist_we    = 1'b1;
			hist_waddr = ctr_q;
		end else if (hs_valid_s1) begin
			hist_we = 1'b1;
			if (!hs_score_s1 && count != socs_pkg::HIST_MAX) begin
				hist_wdata = count + 16'd1;
			end else if (!hs_score_s1) begin
				hist_wdata = count;
			end
		end
	end

	// Weight write: set to one by the clearing sweep, or loaded by an item.
	always_comb begin
		weight_we    = 1'b0;
		weight_waddr = cmd.value;
		weight_wdata = cmd.weight;
		if (state_q == socs_pkg::ST_CLEAR) begin
			weight_we    = 1'b1;
			weight_waddr = ctr_q;
			weight_wdata = socs_pkg::WEIGHT_INIT;
		end else if (state_q == socs_pkg::ST_IDLE && cmd_valid &&
				cmd.op == socs_pkg::ACT_LOAD) begin
			weight_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_waddr] <= hist_wdata;
		end
		if (rd_en) begin
			hist_rdata_s1 <= hist_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (weight_we) begin
			weight_mem[weight_waddr] <= weight_wdata;
		end
		if (rd_en) begin
			weight_rdata_s1 <= weight_mem[rd_addr];
		end
	end

	// Reward: base plus halving bonuses for each extra occurrence.
	always_comb begin
		if (count - 16'd1 >= 16'(socs_pkg::BONUS_STEPS)) begin
			steps = socs_pkg::BONUS_STEPS;
		end else begin
			steps = count[3:0] - 4'd1;
		end
		reward = socs_pkg::REWARD_BASE + (socs_pkg::REWARD_BONUS << 1) -
			((socs_pkg::REWARD_BONUS << 1) >> steps);
	end

	// Layer weight from the distance of the popcount to k/2.
	always_comb begin
		rank = 4'd0;
		for (int b = 0; b < AW; b++) begin
			rank = rank + 4'(hs_addr_s1[b]);
		end
		if (rank == half) begin
			term = 14'(reward) << 3;
		end else if (rank + 4'd1 == half || rank == half + 4'd1) begin
			term = 14'(reward) << 2;
		end else begin
			term = 14'(reward);
		end
	end

	assign in_range = (hs_addr_s1 != '0) && ((hs_addr_s1 & ~kmask) == '0);

	// Accumulate over covered masks; cleared as a finish starts.
	always_ff @(posedge clk) begin
		if (state_q == socs_pkg::ST_IDLE) begin
			cov_q  <= '0;
			pot_q  <= '0;
			wsum_q <= '0;
		end else if (hs_valid_s1 && hs_score_s1 && in_range && count != 16'd0) begin
			cov_q <= cov_q + AW'(1);
			pot_q <= pot_q + 26'(term);
			if (use_weights) begin
				wsum_q <= wsum_q + 28'(weight_rdata_s1);
			end else begin
				wsum_q <= wsum_q + 28'd1;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.covered_masks   <= cov_q;
			res_q.potential_score <= pot_q;
			res_q.weighted_cover  <= wsum_q;
			res_q.all_covered     <= (cov_q == kmask);
		end
	end

	assign clearing  = (state_q == socs_pkg::ST_CLEAR);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: rtl/core/subarray_or_coverage_scorer.sv
// Subarray OR coverage scorer.
// Items arrive on the s_axis channel; tuser carries the action (push element,
// load weight, finish). A push ORs the element into the list of distinct
// subarray ORs and counts each resulting value in a 4096-entry histogram; a
// load writes a 16-bit weight for one mask; a finish scans every mask and
// returns one result item on m_axis, then clears the list and the histogram.
// A front stage classifies items into a four-entry queue, so items are taken
// while the back is busy. A push occupies the back for a walk over the stored
// OR values, with one histogram read-modify-write for each distinct OR value.
// A load writes its weight from the idle state. A finish scans one histogram
// and weight memory address per cycle, and its result is held in an output
// register until the receiver takes it; while that register is full, a further
// finish waits and the queue fills. After reset a clearing pass over all 4096
// addresses sets the histogram to zero and all weights to one; no item is
// accepted during it, configuration writes are.
// Configuration: index 0 is word_bits (reset 12), index 1 is use_weights
// (reset 1); write them only while the block is idle.
module subarray_or_coverage_scorer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,   // element_value [11:0], mask_weight [27:12]
	input  logic [1:0]   s_axis_tuser,   // action [1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata,   // covered_masks [11:0], potential_score [37:12],
	                                     // weighted_cover [65:38], all_covered [66]
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [3:0]   cfg_wdata
);

	logic [3:0]         word_bits_q;
	logic               use_weights_q;
	logic               clearing;
	logic               fr_valid;
	logic               fr_ready;
	socs_pkg::cmd_t     fr_cmd;
	logic               q_valid;
	logic               q_ready;
	socs_pkg::cmd_t     q_cmd;
	socs_pkg::result_t  res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_bits_q   <= socs_pkg::WORD_BITS_INIT;
			use_weights_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				socs_pkg::CFG_WORD_BITS:   word_bits_q   <= cfg_wdata;
				socs_pkg::CFG_USE_WEIGHTS: use_weights_q <= cfg_wdata[0];
				default:                   word_bits_q   <= word_bits_q;
			endcase
		end
	end

	socs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.word_bits     (word_bits_q),
		.clearing      (clearing),
		.cmd_valid     (fr_valid),
		.cmd_ready     (fr_ready),
		.cmd           (fr_cmd)
	);

	socs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_cmd    (fr_cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	socs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.word_bits   (word_bits_q),
		.use_weights (use_weights_q),
		.cmd_valid   (q_valid),
		.cmd_ready   (q_ready),
		.cmd         (q_cmd),
		.clearing    (clearing),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res         (res)
	);

	// Pack the result, first field lowest.
	assign m_axis_tdata = {5'd0, res.all_covered, res.weighted_cover,
		res.potential_score, res.covered_masks};

endmodule

// File: tb/tb_subarray_or_coverage_scorer.sv
module tb_subarray_or_coverage_scorer;

	localparam int CYCLE_LIMIT = 40_000_000;
	localparam int QUIET       = 120;
	localparam int RANDOM_GOAL = 1800;
	localparam int CALM_AFTER  = 1500;
	localparam int PLAN_LEN    = 30;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b1;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;
	logic [1:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic        cfg_we        = 1'b0;
	logic        cfg_index     = 1'b0;
	logic [3:0]  cfg_wdata     = '0;

	subarray_or_coverage_scorer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // element_value [11:0], mask_weight [27:12]
		.s_axis_tuser  (s_axis_tuser),   // action [1:0]
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // covered_masks [11:0], potential_score [37:12],
		                                 // weighted_cover [65:38], all_covered [66]
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Shadow copy of the scorer state.
	logic [11:0] or_chain [socs_pkg::LIST_DEPTH];
	int          chain_len;
	logic [15:0] hit_count [socs_pkg::STORE_DEPTH];
	logic [15:0] mask_weight_mem [socs_pkg::STORE_DEPTH];
	logic [3:0]  word_bits_reg;
	logic        use_weights_reg;

	socs_pkg::result_t pending_scores [$];

	int fail_count   = 0;
	int items_sent   = 0;
	int scores_seen  = 0;
	int full_covers  = 0;
	bit calm         = 1'b0;
	bit tx_choppy    = 1'b1;
	bit rx_choppy    = 1'b1;

	// One row of the directed plan: a register write or an item, with an
	// optional hand-written score for a finish.
	typedef struct packed {
		bit                 cfg_row;
		logic               reg_sel;
		logic [3:0]         reg_val;
		socs_pkg::action_t  act;
		logic [11:0]        elem;
		logic [15:0]        wt;
		bit                 typed;
		socs_pkg::result_t  want;
	} plan_row_t;

	plan_row_t plan [PLAN_LEN];

	function automatic plan_row_t item_row(input socs_pkg::action_t act,
			input logic [11:0] elem, input logic [15:0] wt);
		plan_row_t r;
		r = '0;
		r.act = act;
		r.elem = elem;
		r.wt = wt;
		return r;
	endfunction

	function automatic plan_row_t reg_row(input logic sel, input logic [3:0] val);
		plan_row_t r;
		r = '0;
		r.cfg_row = 1'b1;
		r.reg_sel = sel;
		r.reg_val = val;
		return r;
	endfunction

	function automatic plan_row_t known_row(input logic [11:0] covered,
			input logic [25:0] potential, input logic [27:0] weighted, input logic all);
		plan_row_t r;
		r = '0;
		r.act = socs_pkg::ACT_FINISH;
		r.typed = 1'b1;
		r.want.covered_masks = covered;
		r.want.potential_score = potential;
		r.want.weighted_cover = weighted;
		r.want.all_covered = all;
		return r;
	endfunction

	// Number of mask bits in force: zero acts as one, large values clamp.
	function automatic int active_bits();
		int kk;
		kk = word_bits_reg;
		if (kk < 1) kk = 1;
		if (kk > socs_pkg::MAX_BITS) kk = socs_pkg::MAX_BITS;
		return kk;
	endfunction

	// Fold one array element into the list of subarray ORs and count them.
	function automatic void fold_element(input logic [11:0] raw);
		logic [11:0] fresh [socs_pkg::LIST_DEPTH];
		logic [11:0] x;
		logic [11:0] v;
		int          n;
		int          i;
		x = raw & 12'((13'd1 << active_bits()) - 13'd1);
		fresh[0] = x;
		n = 1;
		for (i = 0; i < chain_len; i++) begin
			v = or_chain[i] | x;
			if (fresh[n-1] != v && n < socs_pkg::LIST_DEPTH) begin
				fresh[n] = v;
				n++;
			end
		end
		for (i = 0; i < n; i++) begin
			if (hit_count[fresh[i]] != socs_pkg::HIST_MAX) hit_count[fresh[i]]++;
			or_chain[i] = fresh[i];
		end
		chain_len = n;
	endfunction

	// Score every mask 1..2^k-1, then clear the list and the histogram.
	function automatic socs_pkg::result_t score_masks();
		socs_pkg::result_t r;
		int              kk;
		int              half;
		int              rank;
		int              m;
		int              occ;
		int unsigned     c;
		int unsigned     reward;
		int unsigned     bonus;
		int unsigned     layer;
		longint unsigned covered;
		longint unsigned potential;
		longint unsigned weighted;
		kk = active_bits();
		half = kk / 2;
		covered = 0;
		potential = 0;
		weighted = 0;
		for (m = 1; m < (1 << kk); m++) begin
			c = hit_count[m];
			if (c != 0) begin
				covered++;
				weighted += use_weights_reg ? mask_weight_mem[m] : 1;
				reward = 1024;
				bonus = 256;
				for (occ = 1; occ < c && bonus != 0; occ++) begin
					reward += bonus;
					bonus >>= 1;
				end
				rank = $countones(m);
				if (rank == half) layer = 8;
				else if (rank + 1 == half || rank == half + 1) layer = 4;
				else layer = 1;
				potential += layer * reward;
			end
		end
		r.covered_masks = covered[11:0];
		r.potential_score = potential[25:0];
		r.weighted_cover = weighted[27:0];
		r.all_covered = (covered == longint'((1 << kk) - 1));
		chain_len = 0;
		for (m = 0; m < socs_pkg::STORE_DEPTH; m++) hit_count[m] = '0;
		return r;
	endfunction

	// Random element: single bits and sparse words build long OR lists,
	// full words exercise masking above k.
	function automatic logic [11:0] pick_element();
		case ($urandom_range(0, 9))
			0: return 12'd0;
			1, 2, 3: return 12'(1 << $urandom_range(0, active_bits() - 1));
			4, 5: return 12'($urandom & $urandom & $urandom);
			default: return 12'($urandom);
		endcase
	endfunction

	// Offer one item, wait for it to be taken, then update the shadow state.
	task automatic send_item(input socs_pkg::action_t act, input logic [11:0] elem,
			input logic [15:0] wt, input bit typed, input socs_pkg::result_t want);
		int gap;
		gap = (!calm && tx_choppy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, wt, elem};
		s_axis_tuser <= act;
		do @(posedge clk); while (!s_axis_tready);
		case (act)
			socs_pkg::ACT_PUSH: fold_element(elem);
			socs_pkg::ACT_LOAD: mask_weight_mem[elem] = wt;
			socs_pkg::ACT_FINISH: begin
				if (typed) begin
					void'(score_masks());
					pending_scores = {pending_scores, want};
				end else begin
					pending_scores = {pending_scores, score_masks()};
				end
			end
			default: ;
		endcase
		if (act != socs_pkg::ACT_NONE) items_sent++;
	endtask

	// Stop sending, wait for every pending score, then let the back end go quiet.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (QUIET) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [3:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == socs_pkg::CFG_WORD_BITS) word_bits_reg = val;
		else use_weights_reg = val[0];
	endtask

	task automatic check_field(input string name, input longint unsigned want_v,
			input longint unsigned got_v);
		if (want_v != got_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
			fail_count++;
		end
	endtask

	// Result side: random stalls, and a field-by-field compare of each item.
	initial begin : score_monitor
		int                stall_left;
		socs_pkg::result_t got;
		socs_pkg::result_t want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got = socs_pkg::result_t'(m_axis_tdata[66:0]);
				if (pending_scores.size() == 0) begin
					$error("result item arrived with no score pending");
					fail_count++;
				end else begin
					want = pending_scores.pop_front();
					check_field("covered_masks", want.covered_masks, got.covered_masks);
					check_field("potential_score", want.potential_score, got.potential_score);
					check_field("weighted_cover", want.weighted_cover, got.weighted_cover);
					check_field("all_covered", want.all_covered, got.all_covered);
					scores_seen++;
					if (want.all_covered) full_covers++;
				end
			end
			if (stall_left > 0) stall_left--;
			else if (!calm && rx_choppy && $urandom_range(0, 3) == 0)
				stall_left = $urandom_range(1, 14);
			if ($urandom_range(0, 299) == 0) rx_choppy = !rx_choppy;
			m_axis_tready <= (stall_left == 0);
		end
	end

	// Watchdog.
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int                base;
		int                phase;
		int                nseq;
		int                len;
		int                pick;
		int                r;
		logic [3:0]        wb;
		logic [15:0]       wt;
		socs_pkg::result_t none;

		arst_n <= 1'b0;
		none = '0;
		word_bits_reg = socs_pkg::WORD_BITS_INIT;
		use_weights_reg = 1'b1;
		chain_len = 0;
		for (r = 0; r < socs_pkg::STORE_DEPTH; r++) begin
			hit_count[r] = '0;
			mask_weight_mem[r] = 16'd1;
		end

		plan = '{
			known_row(12'd0, 26'd0, 28'd0, 1'b0),                  // nothing pushed yet
			item_row(socs_pkg::ACT_NONE, 12'hFFF, 16'hFFFF),       // unused action is dropped
			known_row(12'd0, 26'd0, 28'd0, 1'b0),
			reg_row(socs_pkg::CFG_WORD_BITS, 4'd0),                // zero acts as one bit
			item_row(socs_pkg::ACT_PUSH, 12'hFFF, 16'd0),
			item_row(socs_pkg::ACT_PUSH, 12'd0, 16'd0),            // zero kept, never scored
			known_row(12'd1, 26'd5120, 28'd1, 1'b1),
			reg_row(socs_pkg::CFG_WORD_BITS, 4'd15),               // clamps to twelve bits
			item_row(socs_pkg::ACT_LOAD, 12'hFFF, 16'hFFFF),
			item_row(socs_pkg::ACT_LOAD, 12'd0, 16'd0),
			item_row(socs_pkg::ACT_LOAD, 12'd1, 16'd0),
			item_row(socs_pkg::ACT_PUSH, 12'hFFF, 16'hFFFF),
			item_row(socs_pkg::ACT_PUSH, 12'd1, 16'd0),
			item_row(socs_pkg::ACT_PUSH, 12'h800, 16'd0),
			item_row(socs_pkg::ACT_PUSH, 12'd0, 16'd0),
			item_row(socs_pkg::ACT_FINISH, 12'd0, 16'd0),
			reg_row(socs_pkg::CFG_USE_WEIGHTS, 4'd0),
			reg_row(socs_pkg::CFG_WORD_BITS, 4'd4),
			item_row(socs_pkg::ACT_PUSH, 12'd1, 16'd0),
			item_row(socs_pkg::ACT_PUSH, 12'd2, 16'd0),
			item_row(socs_pkg::ACT_PUSH, 12'd4, 16'd0),
			item_row(socs_pkg::ACT_PUSH, 12'd8, 16'd0),
			item_row(socs_pkg::ACT_PUSH, 12'd16, 16'd0),           // wider than k, masked off
			item_row(socs_pkg::ACT_FINISH, 12'd0, 16'd0),
			reg_row(socs_pkg::CFG_USE_WEIGHTS, 4'd1),
			reg_row(socs_pkg::CFG_WORD_BITS, 4'd2),
			item_row(socs_pkg::ACT_PUSH, 12'd3, 16'd0),
			item_row(socs_pkg::ACT_PUSH, 12'd1, 16'd0),
			item_row(socs_pkg::ACT_PUSH, 12'd2, 16'd0),
			item_row(socs_pkg::ACT_FINISH, 12'd0, 16'd0)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed plan.
		for (r = 0; r < PLAN_LEN; r++) begin
			if (plan[r].cfg_row) begin
				settle();
				write_reg(plan[r].reg_sel, plan[r].reg_val);
			end else begin
				send_item(plan[r].act, plan[r].elem, plan[r].wt, plan[r].typed,
					plan[r].want);
			end
		end

		// Random phases: settings first, then runs of pushes closed by a finish.
		base = items_sent;
		phase = 0;
		while (items_sent - base < RANDOM_GOAL) begin
			settle();
			case (phase)
				0: wb = 4'd1;
				1: wb = 4'd12;
				2: wb = 4'd0;
				3: wb = 4'd15;
				4: wb = 4'd2;
				default: wb = 4'($urandom_range(0, 15));
			endcase
			write_reg(socs_pkg::CFG_WORD_BITS, wb);
			write_reg(socs_pkg::CFG_USE_WEIGHTS,
				(phase < 2) ? 4'(phase) : 4'($urandom_range(0, 1)));
			nseq = $urandom_range(1, 3);
			repeat (nseq) begin
				calm = (items_sent - base) > CALM_AFTER;
				tx_choppy = ($urandom_range(0, 2) != 0);
				len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 60);
				repeat (len) begin
					pick = $urandom_range(0, 99);
					if (pick < 8) begin
						case ($urandom_range(0, 3))
							0: wt = 16'd0;
							1: wt = 16'hFFFF;
							default: wt = 16'($urandom);
						endcase
						send_item(socs_pkg::ACT_LOAD, 12'($urandom), wt, 1'b0, none);
					end else if (pick < 11) begin
						send_item(socs_pkg::ACT_NONE, 12'($urandom), 16'($urandom),
							1'b0, none);
					end else begin
						send_item(socs_pkg::ACT_PUSH, pick_element(), 16'($urandom),
							1'b0, none);
					end
				end
				// Now and then a run is left open and carries into the next one.
				if ($urandom_range(0, 9) != 0)
					send_item(socs_pkg::ACT_FINISH, 12'($urandom), 16'($urandom),
						1'b0, none);
			end
			phase++;
		end
		send_item(socs_pkg::ACT_FINISH, 12'($urandom), 16'($urandom), 1'b0, none);
		settle();

		$display("tb: %0d items over %0d setting phases, %0d scores compared, %0d fully covered",
			items_sent, phase, scores_seen, full_covers);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/socs_pkg.sv
rtl/core/socs_front.sv
rtl/core/socs_queue.sv
rtl/core/socs_back.sv
rtl/core/subarray_or_coverage_scorer.sv
tb/tb_subarray_or_coverage_scorer.sv
